// ===== design/ascii_integer_parser_defines.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the ASCII integer parser
// Shared concurrent assertion forms for the checker.
// ----------------------------------------------------------------------------
`ifndef ASCII_INTEGER_PARSER_DEFINES_SVH
`define ASCII_INTEGER_PARSER_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define AIP_ASSERT_SAME(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("parser assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define AIP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("parser assertion failed");

`endif

// ===== design/aip_pkg.sv =====
// ----------------------------------------------------------------------------
// ASCII integer parser package
// Widths, character codes and the parse phase type shared by the parser files.
// ----------------------------------------------------------------------------
package aip_pkg;

	localparam int unsigned CharW  = 8;
	localparam int unsigned ValueW = 32;

	localparam logic [CharW-1:0] ChMinus = 8'h2D;
	localparam logic [CharW-1:0] ChQuote = 8'h27;
	localparam logic [CharW-1:0] ChZero  = 8'h30;
	localparam logic [CharW-1:0] ChLowX  = 8'h78;
	localparam logic [CharW-1:0] ChUpX   = 8'h58;

	typedef enum logic [2:0] {
		PH_SKIP  = 3'd0,
		PH_START = 3'd1,
		PH_ZERO  = 3'd2,
		PH_HEX   = 3'd3,
		PH_QUOTE = 3'd4,
		PH_DEC   = 3'd5,
		PH_DONE  = 3'd6
	} phase_t;

endpackage

// ===== design/aip_char_if.sv =====
// ----------------------------------------------------------------------------
// Character channel
// Valid/ready channel carrying one string byte and its end flag per beat.
// ----------------------------------------------------------------------------
interface aip_char_if;

	logic                        valid;
	logic                        ready;
	logic [aip_pkg::CharW-1:0]   char_code;
	logic                        end_of_string;

	modport source (output valid, char_code, end_of_string, input ready);
	modport sink (input valid, char_code, end_of_string, output ready);

endinterface

// ===== design/aip_value_if.sv =====
// ----------------------------------------------------------------------------
// Value channel
// Valid/ready channel carrying one parsed signed 32-bit value per beat.
// ----------------------------------------------------------------------------
interface aip_value_if;

	logic                               valid;
	logic                               ready;
	logic signed [aip_pkg::ValueW-1:0]  value;

	modport source (output valid, value, input ready);
	modport sink (input valid, value, output ready);

endinterface

// ===== design/ascii_integer_parser.sv =====
// ----------------------------------------------------------------------------
// ASCII integer parser
// Streams string bytes in and returns one signed 32-bit value per string.
// ----------------------------------------------------------------------------
// Usage: each beat on chars carries one byte of a string; the beat with
// end_of_string set closes the string. Leading bytes 1 to 32 are skipped, an
// optional minus sign is taken, then hex after 0x or 0X, a quoted character
// read as signed 8-bit, or decimal is read. A byte that does not fit, or a
// zero byte, ends the parse; later bytes up to the end flag are ignored.
// One beat leaves on result for each string, after its closing beat.
// Throughput: one byte per cycle while no closing beat waits on a stalled
// result, set by the update of the phase and accumulator registers. Each
// result passes the input register, then the result register.
// Reset clears the parse state and empties both registers.
// When result stalls, bytes that do not close a string still flow; a closing
// beat waits in the input register until the result register is free.
// ----------------------------------------------------------------------------
module ascii_integer_parser (
	input  logic               clk,
	input  logic               arst_n,
	aip_char_if.sink           chars,
	aip_value_if.source        result
);

	logic                              valid_s1;
	logic [aip_pkg::CharW-1:0]         char_s1;
	logic                              eos_s1;
	logic                              advance_s1;

	aip_pkg::phase_t                   phase_q;
	logic                              neg_q;
	logic [aip_pkg::ValueW-1:0]        acc_q;

	aip_pkg::phase_t                   phase_nxt;
	logic                              neg_nxt;
	logic [aip_pkg::ValueW-1:0]        acc_nxt;

	logic                              valid_s2;
	logic [aip_pkg::ValueW-1:0]        value_s2;

	logic                              is_dec;
	logic                              is_hex_lc;
	logic                              is_hex_uc;
	logic [aip_pkg::ValueW-1:0]        dec_acc;
	logic [3:0]                        hex_nib;

	assign advance_s1  = valid_s1 && (!eos_s1 || !valid_s2 || result.ready);
	assign chars.ready = !valid_s1 || advance_s1;

	always_comb begin
		is_dec    = char_s1 inside {[8'h30:8'h39]};
		is_hex_lc = char_s1 inside {[8'h61:8'h66]};
		is_hex_uc = char_s1 inside {[8'h41:8'h46]};
		dec_acc   = (acc_q << 3) + (acc_q << 1) + {28'd0, char_s1[3:0]};
		hex_nib   = is_dec ? char_s1[3:0] : char_s1[3:0] + 4'd9;
	end

	always_comb begin
		phase_nxt = phase_q;
		neg_nxt   = neg_q;
		acc_nxt   = acc_q;
		case (phase_q)
			aip_pkg::PH_SKIP, aip_pkg::PH_START: begin
				if (phase_q == aip_pkg::PH_SKIP && char_s1 inside {[8'd1:8'd32]}) begin
					phase_nxt = aip_pkg::PH_SKIP;
				end else if (phase_q == aip_pkg::PH_SKIP && char_s1 == aip_pkg::ChMinus) begin
					neg_nxt   = 1'b1;
					phase_nxt = aip_pkg::PH_START;
				end else if (char_s1 == aip_pkg::ChZero) begin
					acc_nxt   = '0;
					phase_nxt = aip_pkg::PH_ZERO;
				end else if (char_s1 == aip_pkg::ChQuote) begin
					acc_nxt   = '0;
					phase_nxt = aip_pkg::PH_QUOTE;
				end else if (is_dec) begin
					acc_nxt   = {28'd0, char_s1[3:0]};
					phase_nxt = aip_pkg::PH_DEC;
				end else begin
					acc_nxt   = '0;
					phase_nxt = aip_pkg::PH_DONE;
				end
			end
			aip_pkg::PH_ZERO, aip_pkg::PH_DEC: begin
				if (phase_q == aip_pkg::PH_ZERO &&
				    (char_s1 == aip_pkg::ChLowX || char_s1 == aip_pkg::ChUpX)) begin
					phase_nxt = aip_pkg::PH_HEX;
				end else if (is_dec) begin
					acc_nxt   = dec_acc;
					phase_nxt = aip_pkg::PH_DEC;
				end else begin
					phase_nxt = aip_pkg::PH_DONE;
				end
			end
			aip_pkg::PH_HEX: begin
				if (is_dec || is_hex_lc || is_hex_uc) begin
					acc_nxt = {acc_q[aip_pkg::ValueW-5:0], hex_nib};
				end else begin
					phase_nxt = aip_pkg::PH_DONE;
				end
			end
			aip_pkg::PH_QUOTE: begin
				acc_nxt   = {{(aip_pkg::ValueW-aip_pkg::CharW){char_s1[7]}}, char_s1};
				phase_nxt = aip_pkg::PH_DONE;
			end
			default: begin
				phase_nxt = aip_pkg::PH_DONE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			phase_q  <= aip_pkg::PH_SKIP;
			neg_q    <= 1'b0;
			acc_q    <= '0;
		end else begin
			if (chars.ready) begin
				valid_s1 <= chars.valid;
			end
			if (advance_s1 && eos_s1) begin
				valid_s2 <= 1'b1;
			end else if (result.ready) begin
				valid_s2 <= 1'b0;
			end
			if (advance_s1) begin
				if (eos_s1) begin
					phase_q <= aip_pkg::PH_SKIP;
					neg_q   <= 1'b0;
					acc_q   <= '0;
				end else begin
					phase_q <= phase_nxt;
					neg_q   <= neg_nxt;
					acc_q   <= acc_nxt;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (chars.ready && chars.valid) begin
			char_s1 <= chars.char_code;
			eos_s1  <= chars.end_of_string;
		end
		if (advance_s1 && eos_s1) begin
			value_s2 <= neg_nxt ? (~acc_nxt + 32'd1) : acc_nxt;
		end
	end

	assign result.valid = valid_s2;
	assign result.value = value_s2;

endmodule

// ===== design/aip_checker.sv =====
// ----------------------------------------------------------------------------
// ASCII integer parser checker
// Port-level assertions on the parser, bound to every parser instance.
// ----------------------------------------------------------------------------
`include "ascii_integer_parser_defines.svh"

module aip_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        in_valid,
	input logic                        in_ready,
	input logic                        in_eos,
	input logic                        out_valid,
	input logic                        out_ready,
	input logic [aip_pkg::ValueW-1:0]  out_value
);

	`AIP_ASSERT_NEXT(a_out_held, clk, arst_n, out_valid && !out_ready, out_valid)
	`AIP_ASSERT_NEXT(a_out_stable, clk, arst_n, out_valid && !out_ready, $stable(out_value))
	`AIP_ASSERT_SAME(a_ready_when_empty, clk, arst_n, !out_valid, in_ready)
	`AIP_ASSERT_SAME(a_result_after_close, clk, arst_n, out_valid && !$past(out_valid), $past(in_valid && in_ready && in_eos, 2))

endmodule

bind ascii_integer_parser aip_checker u_aip_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (chars.valid),
	.in_ready  (chars.ready),
	.in_eos    (chars.end_of_string),
	.out_valid (result.valid),
	.out_ready (result.ready),
	.out_value (result.value)
);

// ===== tb/tb_ascii_integer_parser.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ASCII integer parser testbench
// Streams strings into the parser a byte per beat and compares every returned
// value with a cycle-free software parse of the same bytes. A directed set of
// corner strings comes first, then random well-formed numbers mixed with
// noise, a pause that lets the pipeline drain under heavy stalling, and a
// final stretch with both sides running flat out.
// ----------------------------------------------------------------------------
module tb_ascii_integer_parser;

	typedef logic [aip_pkg::CharW-1:0]  char_t;
	typedef char_t                      char_q_t[$];
	typedef logic [aip_pkg::ValueW-1:0] value_t;

	localparam char_t ChNul   = 8'h00;
	localparam char_t ChSpace = 8'h20;
	localparam char_t ChBang  = 8'h21;
	localparam char_t ChNine  = 8'h39;
	localparam char_t ChUpA   = 8'h41;
	localparam char_t ChUpF   = 8'h46;
	localparam char_t ChLowA  = 8'h61;
	localparam char_t ChLowF  = 8'h66;

	localparam int ReportLimit  = 10;
	localparam int SettleCycles = 10;
	localparam int BurstMax     = 18;

	logic clk;
	logic arst_n;

	aip_char_if  chars();
	aip_value_if result();

	ascii_integer_parser dut (
		.clk    (clk),
		.arst_n (arst_n),
		.chars  (chars),
		.result (result)
	);

	aip_pkg::phase_t parse_phase;
	logic            parse_negative;
	value_t          parse_acc;
	value_t          expected_values[$];

	int items_sent;
	int mismatches;
	int send_idle_pct;
	int stall_pct;

	function automatic logic is_digit(char_t c);
		return c >= aip_pkg::ChZero && c <= ChNine;
	endfunction

	function automatic void reset_parse();
		parse_phase    = aip_pkg::PH_SKIP;
		parse_negative = 1'b0;
		parse_acc      = '0;
	endfunction

	function automatic void take_decimal(char_t c);
		if (is_digit(c)) begin
			parse_acc   = parse_acc * 10 + value_t'(c - aip_pkg::ChZero);
			parse_phase = aip_pkg::PH_DEC;
		end else begin
			parse_phase = aip_pkg::PH_DONE;
		end
	endfunction

	function automatic void open_form(char_t c);
		parse_acc = '0;
		if (c == aip_pkg::ChZero) begin
			parse_phase = aip_pkg::PH_ZERO;
		end else if (c == aip_pkg::ChQuote) begin
			parse_phase = aip_pkg::PH_QUOTE;
		end else begin
			take_decimal(c);
		end
	endfunction

	function automatic void parse_char(char_t c, logic last);
		case (parse_phase)
			aip_pkg::PH_SKIP: begin
				if (c >= 8'h01 && c <= ChSpace) begin
				end else if (c == aip_pkg::ChMinus) begin
					parse_negative = 1'b1;
					parse_phase    = aip_pkg::PH_START;
				end else begin
					open_form(c);
				end
			end
			aip_pkg::PH_START: open_form(c);
			aip_pkg::PH_ZERO: begin
				if (c == aip_pkg::ChLowX || c == aip_pkg::ChUpX) begin
					parse_phase = aip_pkg::PH_HEX;
				end else begin
					take_decimal(c);
				end
			end
			aip_pkg::PH_HEX: begin
				if (is_digit(c)) begin
					parse_acc = {parse_acc[aip_pkg::ValueW-5:0], 4'(c - aip_pkg::ChZero)};
				end else if (c >= ChLowA && c <= ChLowF) begin
					parse_acc = {parse_acc[aip_pkg::ValueW-5:0], 4'(c - ChLowA + 8'd10)};
				end else if (c >= ChUpA && c <= ChUpF) begin
					parse_acc = {parse_acc[aip_pkg::ValueW-5:0], 4'(c - ChUpA + 8'd10)};
				end else begin
					parse_phase = aip_pkg::PH_DONE;
				end
			end
			aip_pkg::PH_QUOTE: begin
				parse_acc   = {{(aip_pkg::ValueW-aip_pkg::CharW){c[aip_pkg::CharW-1]}}, c};
				parse_phase = aip_pkg::PH_DONE;
			end
			aip_pkg::PH_DEC: take_decimal(c);
			default: parse_phase = aip_pkg::PH_DONE;
		endcase
		if (last) begin
			expected_values.push_back(parse_negative ? -parse_acc : parse_acc);
			reset_parse();
		end
	endfunction

	function automatic char_q_t make_number_text();
		char_q_t q;
		int      v;
		repeat ($urandom_range(0, 3)) q.push_back(char_t'($urandom_range(1, 32)));
		if ($urandom_range(2) == 0) q.push_back(aip_pkg::ChMinus);
		case ($urandom_range(3))
			0: begin
				repeat ($urandom_range(1, 12))
					q.push_back(aip_pkg::ChZero + char_t'($urandom_range(9)));
			end
			1: begin
				q.push_back(aip_pkg::ChZero);
				q.push_back($urandom_range(1) ? aip_pkg::ChLowX : aip_pkg::ChUpX);
				repeat ($urandom_range(0, 10)) begin
					v = $urandom_range(15);
					if (v < 10) begin
						q.push_back(aip_pkg::ChZero + char_t'(v));
					end else begin
						q.push_back(($urandom_range(1) ? ChLowA : ChUpA) + char_t'(v - 10));
					end
				end
			end
			2: begin
				q.push_back(aip_pkg::ChQuote);
				if ($urandom_range(7) != 0) q.push_back(char_t'($urandom_range(255)));
			end
			default: q.push_back(aip_pkg::ChZero);
		endcase
		repeat ($urandom_range(0, 3)) q.push_back(char_t'($urandom_range(255)));
		return q;
	endfunction

	task automatic send_char(char_t c, logic last);
		if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
			chars.valid         <= 1'b0;
			chars.char_code     <= char_t'($urandom);
			chars.end_of_string <= 1'($urandom);
			repeat ($urandom_range(1, BurstMax)) @(negedge clk);
		end
		chars.valid         <= 1'b1;
		chars.char_code     <= c;
		chars.end_of_string <= last;
		do @(posedge clk); while (!chars.ready);
		parse_char(c, last);
		items_sent++;
		@(negedge clk);
	endtask

	task automatic send_bytes(char_q_t q);
		foreach (q[i]) send_char(q[i], i == q.size() - 1);
	endtask

	task automatic send_text(string s);
		char_q_t q;
		for (int i = 0; i < s.len(); i++) q.push_back(s[i]);
		send_bytes(q);
	endtask

	task automatic wait_drained();
		chars.valid <= 1'b0;
		do @(negedge clk); while (expected_values.size() != 0);
	endtask

	task automatic send_random_strings(int item_count);
		int      stop_at;
		char_q_t q;
		stop_at = items_sent + item_count;
		while (items_sent < stop_at) begin
			if ($urandom_range(4) == 0) begin
				q = {};
				repeat ($urandom_range(1, 8)) q.push_back(char_t'($urandom_range(255)));
			end else begin
				q = make_number_text();
			end
			send_bytes(q);
		end
	endtask

	task automatic test_directed();
		send_idle_pct = 15;
		stall_pct     = 15;
		send_text("0");
		send_text("-2147483648");
		send_text("2147483647");
		send_text("99999999999");
		send_bytes('{8'h01, ChSpace, 8'h1F, 8'h09, aip_pkg::ChMinus, 8'h34, 8'h32});
		send_text("0x7fffFFFF");
		send_text("-0XDEADbeef");
		send_text("0x");
		send_text("0xg1");
		send_text("0x123456789abc");
		send_text("'A");
		send_bytes('{aip_pkg::ChQuote, 8'hFF});
		send_bytes('{aip_pkg::ChMinus, aip_pkg::ChQuote, 8'h80});
		send_text("'");
		send_text("--5");
		send_bytes('{ChNul});
		send_text("   ");
		send_text("12a34");
		send_text("007");
		send_bytes('{8'h31, 8'h32, ChNul, 8'h33});
		send_text("+5");
		send_bytes('{ChBang, 8'h35});
		send_text("-0");
		send_text("0x-1");
	endtask

	task automatic test_random_strings();
		send_idle_pct = 12;
		stall_pct     = 12;
		send_random_strings(700);
		send_idle_pct = 0;
		stall_pct     = 0;
		send_random_strings(150);
		send_idle_pct = 30;
		stall_pct     = 5;
		send_random_strings(250);
		send_idle_pct = 5;
		stall_pct     = 35;
		send_random_strings(250);
	endtask

	task automatic test_drain_pause();
		send_idle_pct = 5;
		stall_pct     = 45;
		repeat (10) send_bytes(make_number_text());
		wait_drained();
		repeat (10) send_bytes(make_number_text());
	endtask

	task automatic test_steady_stream();
		send_idle_pct = 0;
		stall_pct     = 0;
		send_random_strings(200);
	endtask

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		int stall_left;
		stall_left   = 0;
		result.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (stall_left > 0) begin
				stall_left--;
				result.ready <= 1'b0;
			end else if (stall_pct > 0 && $urandom_range(99) < stall_pct) begin
				stall_left   = $urandom_range(1, BurstMax) - 1;
				result.ready <= 1'b0;
			end else begin
				result.ready <= 1'b1;
			end
		end
	end

	// Each value beat is matched against the oldest string still awaiting its value.
	initial begin
		value_t want;
		forever begin
			@(posedge clk);
			if (arst_n && result.valid && result.ready) begin
				if (expected_values.size() == 0) begin
					mismatches++;
					if (mismatches <= ReportLimit)
						$display("unexpected value beat: got %0d", result.value);
				end else begin
					want = expected_values.pop_front();
					if (result.value !== want) begin
						mismatches++;
						if (mismatches <= ReportLimit)
							$display("value mismatch: expected %0d, got %0d",
								$signed(want), result.value);
					end
				end
			end
		end
	end

	initial begin
		#2000000;
		$display("** ascii_integer_parser: FAILED **");
		$finish;
	end

	initial begin
		arst_n              = 1'b0;
		chars.valid         = 1'b0;
		chars.char_code     = '0;
		chars.end_of_string = 1'b0;
		items_sent          = 0;
		mismatches          = 0;
		send_idle_pct       = 0;
		stall_pct           = 0;
		reset_parse();
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		test_directed();
		test_random_strings();
		test_drain_pause();
		test_steady_stream();
		wait_drained();
		repeat (SettleCycles) @(negedge clk);
		if (mismatches == 0 && expected_values.size() == 0) begin
			$display("** ascii_integer_parser: PASSED **");
		end else begin
			$display("** ascii_integer_parser: FAILED **");
		end
		$finish;
	end

endmodule
